### rtl/hsr_pkg.sv
// ---------------------------------------------------------------------------
// hsr_pkg : shared constants for the two-wire humidity sensor reader
// Phase codes, register indexes, protocol waveform tables and command codes.
// ---------------------------------------------------------------------------
package hsr_pkg;

  // sequencer phases
  localparam logic [2:0] PH_RSTCLK = 3'd0;
  localparam logic [2:0] PH_IDLE   = 3'd1;
  localparam logic [2:0] PH_START  = 3'd2;
  localparam logic [2:0] PH_CMD    = 3'd3;
  localparam logic [2:0] PH_POLL   = 3'd4;
  localparam logic [2:0] PH_READ   = 3'd5;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_POLL   = 2'd2;

  localparam int unsigned RESET_CLOCKS = 9;
  localparam logic [32:0] RSTCLK_TICKS = 33'(2 * RESET_CLOCKS);

  // start pattern, bit n is tick n
  localparam logic [6:0] START_SCK  = 7'b0110110;
  localparam logic [6:0] START_DATA = 7'b1100011;

  localparam logic [15:0] CMD_TEMP = 16'd3;
  localparam logic [15:0] CMD_HUM  = 16'd5;

  // output beat layout
  localparam int unsigned OUT_W = 80;

endpackage

### rtl/hsr_calc.sv
// ---------------------------------------------------------------------------
// hsr_calc : temperature and humidity compensation
// One shared 25x25 multiplier forms the two products, then a reciprocal
// estimate of the quotient by 1e6. The estimate is multiplied back and fixed
// up by two compare and subtract steps.
// ---------------------------------------------------------------------------
module hsr_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        temp_word_i,
  input  logic [15:0]        hum_word_i,
  output logic               done_o,
  output logic signed [16:0] temp_centi_o,
  output logic signed [21:0] hum_centi_o
);

  localparam logic [3:0] C_IDLE = 4'd0;
  localparam logic [3:0] C_PREP = 4'd1;
  localparam logic [3:0] C_MUL1 = 4'd2;
  localparam logic [3:0] C_MUL2 = 4'd3;
  localparam logic [3:0] C_SUM  = 4'd4;
  localparam logic [3:0] C_REC  = 4'd5;
  localparam logic [3:0] C_BACK = 4'd6;
  localparam logic [3:0] C_FIX  = 4'd7;
  localparam logic [3:0] C_DONE = 4'd8;

  // floor(2^40 / 1e6); applied to the magnitude shifted down by 16
  localparam logic signed [24:0] RECIP   = 25'sd1099511;
  localparam logic signed [24:0] DIVISOR = 25'sd1000000;
  localparam logic [21:0]        DIV22   = 22'd1000000;

  logic [3:0]         st_q;
  logic [1:0]         cnt_q;
  logic [15:0]        t_q, s_q;
  logic signed [24:0] a_q, b_q, c_q, sx_q;
  logic signed [16:0] tc_q;
  logic signed [49:0] prod_q;
  logic signed [49:0] acc_q;
  logic               neg_q;
  logic [39:0]        mag_q;
  logic [20:0]        quo_q;
  logic [21:0]        rem_q;
  logic signed [24:0] mx, my;
  logic signed [49:0] sum;
  logic [49:0]        mag;
  logic [20:0]        qest;
  logic [39:0]        rem_full;
  logic [21:0]        rem_sub;
  logic               rem_ge;

  // shared multiplier operand select
  always_comb begin
    mx = a_q;
    my = b_q;
    case (st_q)
      C_MUL2: begin
        mx = sx_q;
        my = c_q;
      end
      C_REC: begin
        mx = signed'({1'b0, mag_q[39:16]});
        my = RECIP;
      end
      C_BACK: begin
        mx = signed'({4'd0, qest});
        my = DIVISOR;
      end
      default: ;
    endcase
  end

  assign sum      = acc_q + prod_q;
  assign mag      = sum[49] ? 50'(-sum) : 50'(sum);
  // estimate is low by at most two
  assign qest     = prod_q[44:24];
  assign rem_full = mag_q - prod_q[39:0];
  assign rem_sub  = rem_q - DIV22;
  assign rem_ge   = (rem_q >= DIV22);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        C_IDLE: if (start_i) st_q <= C_PREP;
        C_PREP: st_q <= C_MUL1;
        C_MUL1: st_q <= C_MUL2;
        C_MUL2: st_q <= C_SUM;
        C_SUM:  st_q <= C_REC;
        C_REC:  st_q <= C_BACK;
        C_BACK: begin
          st_q  <= C_FIX;
          cnt_q <= '0;
        end
        C_FIX: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd2) st_q <= C_DONE;
        end
        C_DONE: begin
          st_q   <= C_IDLE;
          done_o <= 1'b1;
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      C_IDLE: begin
        if (start_i) begin
          t_q <= temp_word_i;
          s_q <= hum_word_i;
        end
      end
      C_PREP: begin
        tc_q <= 17'(signed'({1'b0, t_q}) - 18'sd4000);
        a_q  <= 25'(signed'({1'b0, t_q}) - 18'sd6500);
        b_q  <= 25'(26'sd10000 + 26'(s_q) * 26'sd80);
        c_q  <= 25'(27'sd4050000 - 27'(s_q) * 27'sd280);
        sx_q <= 25'(s_q);
      end
      C_MUL1: prod_q <= mx * my;
      C_MUL2: begin
        acc_q  <= prod_q - 50'sd400000000;
        prod_q <= mx * my;
      end
      C_SUM: begin
        neg_q <= sum[49];
        mag_q <= mag[39:0];
      end
      C_REC: prod_q <= mx * my;
      C_BACK: begin
        quo_q  <= qest;
        prod_q <= mx * my;
      end
      C_FIX: begin
        if (cnt_q == 2'd0) begin
          rem_q <= rem_full[21:0];
        end else if (rem_ge) begin
          rem_q <= rem_sub;
          quo_q <= quo_q + 21'd1;
        end
      end
      C_DONE: begin
        temp_centi_o <= tc_q;
        hum_centi_o  <= neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
      end
      default: ;
    endcase
  end

endmodule

### rtl/two_wire_humidity_sensor_reader.sv
// ---------------------------------------------------------------------------
// two_wire_humidity_sensor_reader : two-wire humidity/temperature readout
// Channel  | dir | beat
// s_axis   | in  | one microsecond tick, sampled data line
// m_axis   | out | pin levels, result flag and stored readings for the tick
// apb      | in  | enable, measure period, poll interval
// Input is held off after the last tick of the humidity read until the
// compensation is done: it runs on one shared multiplier, with the
// division by 1e6 done as a reciprocal multiply, a multiply back and two
// correction steps. A held output beat stalls input via s_axis_tready_o.
// Reset is asynchronous, active low, and leaves the sequencer at the start
// of the reset clocks with the block enabled.
// ---------------------------------------------------------------------------
module two_wire_humidity_sensor_reader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [0] data_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] sck [1] data_oe [2] data_out [3] result_valid [19:4] temperature_raw
  // [35:20] humidity_raw [52:36] temperature_centi [74:53] humidity_centi
  output logic [79:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        en_q;
  logic [31:0] period_q;
  logic [19:0] poll_q;
  logic [2:0]  phase_q, phase_d;
  logic        step_q, step_d;
  logic [31:0] wait_q, wait_d;
  logic [15:0] sh_q, sh_d, tw_q, tw_d, hw_q, hw_d;
  logic        busy_q;
  logic        mval_q;
  logic [79:0] mdat_q;
  logic        sck, oe, dout, fin;
  logic [32:0] t1;
  logic [2:0]  si;
  logic        d;
  logic        acc;
  logic        cdone;
  logic signed [16:0] tc_r;
  logic signed [21:0] hc_r;

  assign pready = 1'b1;
  assign d      = s_axis_tdata_i[0];
  assign s_axis_tready_o = !busy_q && (!mval_q || m_axis_tready_i);
  assign acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = mval_q;
  assign m_axis_tdata_o  = mdat_q;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b1;
      period_q <= 32'd2000000;
      poll_q   <= 20'd10000;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        hsr_pkg::REG_ENABLE: en_q     <= pwdata[0];
        hsr_pkg::REG_PERIOD: period_q <= pwdata;
        hsr_pkg::REG_POLL:   poll_q   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      hsr_pkg::REG_ENABLE: prdata = {31'd0, en_q};
      hsr_pkg::REG_PERIOD: prdata = period_q;
      hsr_pkg::REG_POLL:   prdata = {12'd0, poll_q};
      default:             prdata = '0;
    endcase
  end

  // tick sequencer
  assign t1 = {1'b0, wait_q} + 33'd1;
  assign si = (wait_q > 32'd6) ? 3'd6 : wait_q[2:0];

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    wait_d  = wait_q;
    sh_d    = sh_q;
    tw_d    = tw_q;
    hw_d    = hw_q;
    sck = 1'b0; oe = 1'b0; dout = 1'b0; fin = 1'b0;
    if (!en_q) begin
      phase_d = hsr_pkg::PH_RSTCLK;
      wait_d  = '0;
      step_d  = 1'b0;
    end else begin
      case (phase_q)
        hsr_pkg::PH_RSTCLK: begin
          oe = 1'b1; dout = 1'b1; sck = !wait_q[0];
          if (t1 >= hsr_pkg::RSTCLK_TICKS) begin
            phase_d = hsr_pkg::PH_IDLE; wait_d = '0;
          end else wait_d = t1[31:0];
        end
        hsr_pkg::PH_IDLE: begin
          oe = 1'b1; dout = 1'b1;
          if (t1 >= {1'b0, period_q}) begin
            phase_d = hsr_pkg::PH_START; wait_d = '0; step_d = 1'b0;
          end else wait_d = t1[31:0];
        end
        hsr_pkg::PH_START: begin
          oe = 1'b1; sck = hsr_pkg::START_SCK[si]; dout = hsr_pkg::START_DATA[si];
          if (si == 3'd6) begin
            phase_d = hsr_pkg::PH_CMD; wait_d = '0;
            sh_d = step_q ? hsr_pkg::CMD_HUM : hsr_pkg::CMD_TEMP;
          end else wait_d = 32'(si) + 32'd1;
        end
        hsr_pkg::PH_CMD: begin
          if (wait_q < 32'd16) begin
            oe = 1'b1; dout = sh_q[7]; sck = wait_q[0];
            if (wait_q[0]) sh_d = {sh_q[14:0], 1'b0};
            wait_d = t1[31:0];
          end else begin
            sck = (wait_q == 32'd17);
            if (wait_q >= 32'd18) begin
              phase_d = hsr_pkg::PH_POLL; wait_d = '0;
            end else wait_d = t1[31:0];
          end
        end
        hsr_pkg::PH_POLL: begin
          if (t1 >= {13'd0, poll_q}) begin
            wait_d = '0;
            if (!d) begin
              phase_d = hsr_pkg::PH_READ; sh_d = '0;
            end
          end else wait_d = t1[31:0];
        end
        hsr_pkg::PH_READ: begin
          if (wait_q < 32'd16 || (wait_q >= 32'd18 && wait_q < 32'd34)) begin
            if (!wait_q[0]) begin
              sck = 1'b1; sh_d = {sh_q[14:0], d};
            end
            wait_d = t1[31:0];
          end else if (wait_q < 32'd18) begin
            oe = 1'b1; dout = 1'b0; sck = (wait_q == 32'd16);
            wait_d = t1[31:0];
          end else begin
            oe = 1'b1; dout = 1'b1; sck = (wait_q == 32'd34);
            if (wait_q >= 32'd35) begin
              wait_d = '0;
              if (!step_q) begin
                tw_d = sh_q; step_d = 1'b1; phase_d = hsr_pkg::PH_START;
              end else begin
                hw_d = sh_q; fin = 1'b1; step_d = 1'b0; phase_d = hsr_pkg::PH_IDLE;
              end
            end else wait_d = t1[31:0];
          end
        end
        default: begin
          phase_d = hsr_pkg::PH_RSTCLK; wait_d = '0; step_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hsr_pkg::PH_RSTCLK;
      step_q  <= 1'b0;
      wait_q  <= '0;
      sh_q    <= '0;
      tw_q    <= '0;
      hw_q    <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (acc) begin
        phase_q <= phase_d;
        step_q  <= step_d;
        wait_q  <= wait_d;
        sh_q    <= sh_d;
        tw_q    <= tw_d;
        hw_q    <= hw_d;
      end
      if (acc && fin) busy_q <= 1'b1;
      else if (cdone)  busy_q <= 1'b0;
    end
  end

  hsr_calc u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (acc && fin),
    .temp_word_i  (tw_q),
    .hum_word_i   (hw_d),
    .done_o       (cdone),
    .temp_centi_o (tc_r),
    .hum_centi_o  (hc_r)
  );

  // result register; results are zero until the first computation
  logic        rv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else if (cdone) rv_q <= 1'b1;
  end

  // output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mval_q <= 1'b0;
      mdat_q <= '0;
    end else begin
      if (cdone) begin
        mval_q <= 1'b1;
        mdat_q <= {5'd0, hc_r, tc_r, hw_q, tw_q, 1'b1, 1'b1, 1'b1, 1'b0};
      end else if (acc && !fin) begin
        mval_q <= 1'b1;
        mdat_q <= {5'd0, rv_q ? hc_r : 22'sd0, rv_q ? tc_r : 17'sd0,
                   hw_d, tw_d, 1'b0, dout, oe, sck};
      end else if (m_axis_tready_i) begin
        mval_q <= 1'b0;
      end
    end
  end

  // checks
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready_o) else $error("tick taken during compute");
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> (!mval_q && busy_q)) else $error("result with beat pending");
  a_dis_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !en_q) |=> (phase_q == hsr_pkg::PH_RSTCLK && wait_q == 32'd0))
    else $error("disabled sequencer not held");

endmodule

### tb/two_wire_humidity_sensor_reader_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_wire_humidity_sensor_reader_tb : self-checking bench for the readout
// Ticks with a random data line level are streamed into the block. A local
// model of the sequencer predicts every output beat: pin levels, the result
// flag and the stored readings. Beats are compared field by field. Register
// settings are changed between phases while no ticks or beats are pending. Both stream
// sides idle at random, and the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------
module two_wire_humidity_sensor_reader_tb;

  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT = 100;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct packed {
    logic        sck;
    logic        oe;
    logic        dout;
    logic        valid;
    logic [15:0] t_raw;
    logic [15:0] h_raw;
    logic [16:0] t_centi;
    logic [21:0] h_centi;
  } tick_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  two_wire_humidity_sensor_reader u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register copies
  logic        cfg_en = 1'b1;
  logic [31:0] cfg_period = 32'd2000000;
  logic [19:0] cfg_poll = 20'd10000;

  // sequencer copy
  logic [2:0]  seq_ph = hsr_pkg::PH_RSTCLK;
  logic        seq_step = 1'b0;
  logic [31:0] seq_cnt = '0;
  logic [15:0] shreg = '0;
  logic [15:0] temp_word = '0;
  logic [15:0] hum_word = '0;
  logic [16:0] temp_res = '0;
  logic [21:0] hum_res = '0;

  tick_out_t   exp_ticks[$];
  logic        tick_q[$];
  int unsigned tx_idle = 29;
  int unsigned rx_idle = 71;
  logic        hold_go = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cnt = 0;

  // one tick of the readout sequencer
  task automatic model_tick(input logic d, output tick_out_t r);
    logic [31:0] t;
    logic [31:0] u;
    longint      tc;
    longint      s;
    longint      num;
    longint      q;
    t = seq_cnt;
    r = '0;
    if (!cfg_en) begin
      seq_ph = hsr_pkg::PH_RSTCLK; seq_cnt = '0; seq_step = 1'b0;
    end else begin
      case (seq_ph)
        hsr_pkg::PH_RSTCLK: begin
          r.oe = 1'b1; r.dout = 1'b1; r.sck = ~t[0];
          if (t + 1 >= 2 * hsr_pkg::RESET_CLOCKS) begin
            seq_ph = hsr_pkg::PH_IDLE; seq_cnt = '0;
          end else seq_cnt = t + 1;
        end
        hsr_pkg::PH_IDLE: begin
          r.oe = 1'b1; r.dout = 1'b1;
          if ({1'b0, t} + 33'd1 >= {1'b0, cfg_period}) begin
            seq_ph = hsr_pkg::PH_START; seq_cnt = '0; seq_step = 1'b0;
          end else seq_cnt = t + 1;
        end
        hsr_pkg::PH_START: begin
          if (t > 6) t = 6;
          r.oe = 1'b1; r.sck = hsr_pkg::START_SCK[t]; r.dout = hsr_pkg::START_DATA[t];
          if (t == 6) begin
            seq_ph = hsr_pkg::PH_CMD; seq_cnt = '0;
            shreg = seq_step ? hsr_pkg::CMD_HUM : hsr_pkg::CMD_TEMP;
          end else seq_cnt = t + 1;
        end
        hsr_pkg::PH_CMD: begin
          if (t < 16) begin
            r.oe = 1'b1; r.dout = shreg[7]; r.sck = t[0];
            if (t[0]) shreg = shreg << 1;
            seq_cnt = t + 1;
          end else begin
            r.sck = (t == 17);
            if (t >= 18) begin
              seq_ph = hsr_pkg::PH_POLL; seq_cnt = '0;
            end else seq_cnt = t + 1;
          end
        end
        hsr_pkg::PH_POLL: begin
          if ({1'b0, t} + 33'd1 >= {13'b0, cfg_poll}) begin
            seq_cnt = '0;
            if (!d) begin
              seq_ph = hsr_pkg::PH_READ; shreg = '0;
            end
          end else seq_cnt = t + 1;
        end
        hsr_pkg::PH_READ: begin
          if (t < 16 || (t >= 18 && t < 34)) begin
            u = (t < 16) ? t : t - 18;
            if (!u[0]) begin
              r.sck = 1'b1; shreg = {shreg[14:0], d};
            end
            seq_cnt = t + 1;
          end else if (t < 18) begin
            // acknowledge after the first byte
            r.oe = 1'b1; r.dout = 1'b0; r.sck = (t == 16);
            seq_cnt = t + 1;
          end else begin
            // no-acknowledge after the second byte
            r.oe = 1'b1; r.dout = 1'b1; r.sck = (t == 34);
            if (t >= 35) begin
              seq_cnt = '0;
              if (!seq_step) begin
                temp_word = shreg; seq_step = 1'b1; seq_ph = hsr_pkg::PH_START;
              end else begin
                hum_word = shreg;
                tc = longint'(temp_word) - 4000;
                s = longint'(hum_word);
                num = (tc - 2500) * (10000 + 80 * s) - 400000000
                      + 4050000 * s - 280 * s * s;
                q = num / 1000000;
                temp_res = tc[16:0];
                hum_res = q[21:0];
                r.valid = 1'b1; seq_step = 1'b0; seq_ph = hsr_pkg::PH_IDLE;
              end
            end else seq_cnt = t + 1;
          end
        end
        default: begin
          seq_ph = hsr_pkg::PH_RSTCLK; seq_cnt = '0; seq_step = 1'b0;
        end
      endcase
    end
    r.t_raw = temp_word;
    r.h_raw = hum_word;
    r.t_centi = temp_res;
    r.h_centi = hum_res;
  endtask

  // register write, setup then access
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      hsr_pkg::REG_ENABLE: cfg_en = val[0];
      hsr_pkg::REG_PERIOD: cfg_period = val;
      hsr_pkg::REG_POLL:   cfg_poll = val[19:0];
      default: ;
    endcase
  endtask

  // wait for all ticks to be taken and all beats to be checked
  task automatic drain();
    do @(posedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid_i || exp_ticks.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic add_ticks(input int unsigned n);
    repeat (n) tick_q.push_back(1'($urandom_range(1)));
  endtask

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {7'b0, tick_q.pop_front()};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // prediction on every accepted tick
  always @(posedge clk_i) begin
    tick_out_t r;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      model_tick(s_axis_tdata_i[0], r);
      exp_ticks.push_back(r);
    end
  end

  // receiver back-pressure, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_go && hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle);
    end
  end

  // output beat checker
  always @(posedge clk_i) begin
    tick_out_t e;
    tick_out_t a;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      a.sck = m_axis_tdata_o[0];
      a.oe = m_axis_tdata_o[1];
      a.dout = m_axis_tdata_o[2];
      a.valid = m_axis_tdata_o[3];
      a.t_raw = m_axis_tdata_o[19:4];
      a.h_raw = m_axis_tdata_o[35:20];
      a.t_centi = m_axis_tdata_o[52:36];
      a.h_centi = m_axis_tdata_o[74:53];
      if (exp_ticks.size() == 0) begin
        $error("output beat with nothing expected");
        err_cnt++;
      end else begin
        e = exp_ticks.pop_front();
        if (a.sck !== e.sck) begin
          $error("sck exp %0d got %0d", e.sck, a.sck); err_cnt++;
        end
        if (a.oe !== e.oe) begin
          $error("data_oe exp %0d got %0d", e.oe, a.oe); err_cnt++;
        end
        if (a.dout !== e.dout) begin
          $error("data_out exp %0d got %0d", e.dout, a.dout); err_cnt++;
        end
        if (a.valid !== e.valid) begin
          $error("result_valid exp %0d got %0d", e.valid, a.valid); err_cnt++;
        end
        if (a.t_raw !== e.t_raw) begin
          $error("temperature_raw exp %0d got %0d", e.t_raw, a.t_raw); err_cnt++;
        end
        if (a.h_raw !== e.h_raw) begin
          $error("humidity_raw exp %0d got %0d", e.h_raw, a.h_raw); err_cnt++;
        end
        if (a.t_centi !== e.t_centi) begin
          $error("temperature_centi exp %0d got %0d",
                 $signed(e.t_centi), $signed(a.t_centi));
          err_cnt++;
        end
        if (a.h_centi !== e.h_centi) begin
          $error("humidity_centi exp %0d got %0d",
                 $signed(e.h_centi), $signed(a.h_centi));
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    logic [23:0] pat;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset clocks and idle at reset settings, both data levels
    pat = 24'b1010_0011_1100_0000_1111_0101;
    for (int i = 0; i < 24; i++) tick_q.push_back(pat[i]);
    drain();

    // fast cycles; shorter period ends the running idle wait at once
    reg_write(hsr_pkg::REG_PERIOD, 32'd5);
    reg_write(hsr_pkg::REG_POLL, 32'd1);
    add_ticks(300);
    drain();

    // zero period and interval act as one tick
    reg_write(hsr_pkg::REG_PERIOD, 32'd0);
    reg_write(hsr_pkg::REG_POLL, 32'd0);
    add_ticks(150);
    drain();

    // disabled, outputs quiet, readings kept
    reg_write(hsr_pkg::REG_ENABLE, 32'd0);
    add_ticks(40);
    drain();

    tx_idle = 71;
    rx_idle = 29;
    // rising enable restarts with the reset clocks
    reg_write(hsr_pkg::REG_ENABLE, 32'd1);
    reg_write(hsr_pkg::REG_PERIOD, 32'd3);
    reg_write(hsr_pkg::REG_POLL, 32'd3);
    add_ticks(300);
    drain();

    // largest settings
    reg_write(hsr_pkg::REG_PERIOD, 32'hFFFF_FFFF);
    reg_write(hsr_pkg::REG_POLL, 32'h000F_FFFF);
    add_ticks(30);
    drain();

    // period back at its reset value
    reg_write(hsr_pkg::REG_PERIOD, 32'd2000000);
    reg_write(hsr_pkg::REG_POLL, 32'd2);
    add_ticks(30);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    // upper poll bits are not stored
    reg_write(hsr_pkg::REG_PERIOD, 32'd1);
    reg_write(hsr_pkg::REG_POLL, 32'hFFF0_0007);
    add_ticks(300);
    drain();

    // long receiver hold-off while ticks keep coming
    reg_write(hsr_pkg::REG_PERIOD, 32'd8);
    reg_write(hsr_pkg::REG_POLL, 32'd2);
    hold_go = 1'b1;
    add_ticks(400);
    drain();

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
